// File: hdl/key_to_id_allocator_assert.svh
// Assertion macros for the key to id allocator.
// Included by the top level; needs no package.
`ifndef KEY_TO_ID_ALLOCATOR_ASSERT_SVH
`define KEY_TO_ID_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define KIA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define KIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define KIA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define KIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: hdl/kia_pkg.sv
// Package of the key to id allocator: sizes, codes, control types.
// Used by every module of the block but kia_ram; depends on nothing.
package kia_pkg;

  localparam int unsigned ID_COUNT = 256;
  localparam int unsigned ID_W     = $clog2(ID_COUNT);
  localparam int unsigned CNT_W    = $clog2(ID_COUNT + 1);
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned ID_OUT_W = 8;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ST_W     = 3;

  localparam logic [ID_W-1:0] ID_MAX = ID_W'(ID_COUNT - 1);

  // command codes; the high bit alone selects clear
  localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REL = 2'd1;

  typedef enum logic [ST_W-1:0] {
    ST_FOUND   = 3'd0,
    ST_NEW     = 3'd1,
    ST_NOFREE  = 3'd2,
    ST_REL     = 3'd3,
    ST_UNBOUND = 3'd4,
    ST_CLEARED = 3'd5
  } kia_status_e;

  // datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SCAN,
    OP_GET_RD,
    OP_GET_WR,
    OP_GET_LNK,
    OP_REL_RD,
    OP_REL_WR,
    OP_CLR_CHK,
    OP_CLR_RD,
    OP_CLR_WR,
    OP_CLR_LNK,
    OP_DONE
  } kia_op_e;

  // datapath status back to the controller
  typedef struct packed {
    logic in_valid;
    logic in_clr;
    logic rel;
    logic hit;
    logic scan_miss;
    logic free_empty;
    logic cur_zero;
    logic out_free;
  } kia_stat_t;

  // reset successor of an id on the free list
  function automatic logic [ID_W-1:0] link_init(input logic [ID_W-1:0] idx);
    logic [ID_W-1:0] nxt;
    nxt = (idx == ID_MAX) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

endpackage

// File: hdl/kia_if.sv
// Handshake channels of the key to id allocator (request and response).
// Depends on kia_pkg for the word field widths.
interface kia_req_if;
  logic                        valid;
  logic                        ready;
  logic [kia_pkg::CMD_W-1:0]   cmd;
  logic [kia_pkg::KEY_W-1:0]   key;
  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

interface kia_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [kia_pkg::ID_OUT_W-1:0] id;
  logic [kia_pkg::ST_W-1:0]     status;
  modport source (output valid, output id, output status, input ready);
  modport sink (input valid, input id, input status, output ready);
endinterface

// File: hdl/kia_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package.
module kia_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/kia_ctrl.sv
// Controller of the key to id allocator: sequences scan, list updates, output.
// Depends on kia_pkg.
module kia_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kia_pkg::kia_stat_t stat_i,
  output kia_pkg::kia_op_e   op_o
);
  import kia_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_SCAN    = 12'b0000_0000_0010,
    S_GET_RD  = 12'b0000_0000_0100,
    S_GET_WR  = 12'b0000_0000_1000,
    S_GET_LNK = 12'b0000_0001_0000,
    S_REL_RD  = 12'b0000_0010_0000,
    S_REL_WR  = 12'b0000_0100_0000,
    S_CLR_CHK = 12'b0000_1000_0000,
    S_CLR_RD  = 12'b0001_0000_0000,
    S_CLR_WR  = 12'b0010_0000_0000,
    S_CLR_LNK = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and operation
  always_comb begin
    state_d = state_q;
    op_o    = OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        op_o = OP_IDLE;
        if (stat_i.in_valid) begin
          state_d = stat_i.in_clr ? S_CLR_CHK : S_SCAN;
        end
      end
      S_SCAN: begin
        op_o = OP_SCAN;
        if (stat_i.hit) begin
          state_d = stat_i.rel ? S_REL_RD : S_DONE;
        end else if (stat_i.scan_miss) begin
          state_d = (stat_i.rel || stat_i.free_empty) ? S_DONE : S_GET_RD;
        end
      end
      S_GET_RD: begin
        op_o    = OP_GET_RD;
        state_d = S_GET_WR;
      end
      S_GET_WR: begin
        op_o    = OP_GET_WR;
        state_d = S_GET_LNK;
      end
      S_GET_LNK: begin
        op_o    = OP_GET_LNK;
        state_d = S_DONE;
      end
      S_REL_RD: begin
        op_o    = OP_REL_RD;
        state_d = S_REL_WR;
      end
      S_REL_WR: begin
        op_o    = OP_REL_WR;
        state_d = S_DONE;
      end
      S_CLR_CHK: begin
        op_o    = OP_CLR_CHK;
        state_d = stat_i.cur_zero ? S_DONE : S_CLR_RD;
      end
      S_CLR_RD: begin
        op_o    = OP_CLR_RD;
        state_d = S_CLR_WR;
      end
      S_CLR_WR: begin
        op_o    = OP_CLR_WR;
        state_d = S_CLR_LNK;
      end
      S_CLR_LNK: begin
        op_o    = OP_CLR_LNK;
        state_d = S_CLR_CHK;
      end
      S_DONE: begin
        op_o = OP_DONE;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        op_o    = OP_IDLE;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/kia_dp.sv
// Datapath of the key to id allocator: key and list memories, list pointers,
// scan pipeline, result and output word register. Depends on kia_pkg, kia_ram.
module kia_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kia_pkg::kia_op_e   op_i,
  output kia_pkg::kia_stat_t stat_o,
  kia_req_if.sink            req_i,
  kia_rsp_if.source          rsp_o
);
  import kia_pkg::*;

  // control state
  logic [ID_W-1:0]  scan_q;
  logic             iss_done_q;
  logic             pipe_v_q;
  logic [ID_W-1:0]  free_head_q, free_tail_q;
  logic [CNT_W-1:0] free_cnt_q;
  logic [ID_W-1:0]  used_head_q, used_tail_q;
  logic             valid_q [ID_COUNT];
  logic             lw_q [ID_COUNT];
  logic             out_valid_q;

  // payload
  logic [KEY_W-1:0] key_q;
  logic             rel_q;
  logic [ID_W-1:0]  pipe_idx_q, cur_q, nx_q, lrd_addr_q;
  logic [ID_W-1:0]  res_id_q;
  kia_status_e      res_st_q;
  logic [ID_OUT_W-1:0] out_id_q;
  kia_status_e      out_st_q;

  // memory ports
  logic             key_we, link_we, prev_we, next_we;
  logic [ID_W-1:0]  key_wa, link_wa, prev_wa, next_wa;
  logic [ID_W-1:0]  key_ra, link_ra, pn_ra;
  logic [KEY_W-1:0] key_rd;
  logic [ID_W-1:0]  link_wd, prev_wd, next_wd;
  logic [ID_W-1:0]  link_rd, prev_rd, next_rd, link_val;

  logic hit, scan_miss, accept, out_free;

  kia_ram #(.DATA_W(KEY_W), .DEPTH(ID_COUNT)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_q),
    .raddr_i(key_ra), .rdata_o(key_rd)
  );
  kia_ram #(.DATA_W(ID_W), .DEPTH(ID_COUNT)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .raddr_i(link_ra), .rdata_o(link_rd)
  );
  kia_ram #(.DATA_W(ID_W), .DEPTH(ID_COUNT)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(pn_ra), .rdata_o(prev_rd)
  );
  kia_ram #(.DATA_W(ID_W), .DEPTH(ID_COUNT)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(pn_ra), .rdata_o(next_rd)
  );

  // never-written free links read as their reset successor
  assign link_val = lw_q[lrd_addr_q] ? link_rd : link_init(lrd_addr_q);

  assign accept    = (op_i == OP_IDLE) && req_i.valid;
  assign hit       = (op_i == OP_SCAN) && pipe_v_q && valid_q[pipe_idx_q] && (key_rd == key_q);
  assign scan_miss = iss_done_q && !pipe_v_q;
  assign out_free  = !out_valid_q || rsp_o.ready;

  // memory addresses and write strobes
  always_comb begin
    key_we  = 1'b0;  key_wa  = cur_q;  key_ra = scan_q;
    link_we = 1'b0;  link_wa = cur_q;  link_wd = '0;  link_ra = free_head_q;
    prev_we = 1'b0;  prev_wa = cur_q;  prev_wd = used_tail_q;
    next_we = 1'b0;  next_wa = cur_q;  next_wd = '0;
    pn_ra   = cur_q;
    case (op_i)
      OP_GET_WR: begin
        key_we  = 1'b1;
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      OP_GET_LNK: begin
        next_we = (used_tail_q != '0);
        next_wa = used_tail_q;
        next_wd = cur_q;
      end
      OP_REL_WR: begin
        next_we = (prev_rd != '0);
        next_wa = prev_rd;
        next_wd = next_rd;
        prev_we = (next_rd != '0);
        prev_wa = next_rd;
        prev_wd = prev_rd;
        link_we = 1'b1;
        link_wd = (free_cnt_q == '0) ? '0 : free_head_q;
      end
      OP_CLR_WR: begin
        link_we = 1'b1;
      end
      OP_CLR_LNK: begin
        link_we = (free_cnt_q != '0);
        link_wa = free_tail_q;
        link_wd = cur_q;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      iss_done_q  <= 1'b0;
      pipe_v_q    <= 1'b0;
      free_head_q <= ID_W'(1);
      free_tail_q <= ID_MAX;
      free_cnt_q  <= CNT_W'(ID_COUNT - 1);
      used_head_q <= '0;
      used_tail_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ID_COUNT; i++) begin
        valid_q[i] <= 1'b0;
        lw_q[i]    <= 1'b0;
      end
    end else begin
      case (op_i)
        OP_IDLE: begin
          if (accept) begin
            scan_q     <= ID_W'(1);
            iss_done_q <= 1'b0;
            pipe_v_q   <= 1'b0;
          end
        end
        // one key RAM read issued per cycle, compared the cycle after
        OP_SCAN: begin
          pipe_v_q <= !iss_done_q;
          if (!iss_done_q) begin
            if (scan_q == ID_MAX) begin
              iss_done_q <= 1'b1;
            end else begin
              scan_q <= scan_q + 1'b1;
            end
          end
        end
        OP_GET_WR: begin
          free_head_q    <= link_val;
          free_cnt_q     <= free_cnt_q - 1'b1;
          valid_q[cur_q] <= 1'b1;
        end
        OP_GET_LNK: begin
          if (used_tail_q == '0) begin
            used_head_q <= cur_q;
          end
          used_tail_q <= cur_q;
        end
        OP_REL_RD: begin
          valid_q[cur_q] <= 1'b0;
        end
        // unlink from in-use list, push onto free list front
        OP_REL_WR: begin
          if (prev_rd == '0) begin
            used_head_q <= next_rd;
          end
          if (next_rd == '0) begin
            used_tail_q <= prev_rd;
          end
          if (free_cnt_q == '0) begin
            free_tail_q <= cur_q;
          end
          free_head_q <= cur_q;
          free_cnt_q  <= free_cnt_q + 1'b1;
          lw_q[cur_q] <= 1'b1;
        end
        OP_CLR_CHK: begin
          if (cur_q == '0) begin
            used_head_q <= '0;
            used_tail_q <= '0;
          end
        end
        OP_CLR_WR: begin
          valid_q[cur_q] <= 1'b0;
          lw_q[cur_q]    <= 1'b1;
        end
        // append to free list tail
        OP_CLR_LNK: begin
          if (free_cnt_q == '0) begin
            free_head_q <= cur_q;
          end else begin
            lw_q[free_tail_q] <= 1'b1;
          end
          free_tail_q <= cur_q;
          free_cnt_q  <= free_cnt_q + 1'b1;
        end
        default: begin
        end
      endcase
      // output word register
      if ((op_i == OP_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_IDLE: begin
        if (accept) begin
          key_q <= req_i.key;
          rel_q <= (req_i.cmd == CMD_REL);
          cur_q <= used_head_q;
        end
      end
      OP_SCAN: begin
        if (!iss_done_q) begin
          pipe_idx_q <= scan_q;
        end
        if (hit) begin
          cur_q    <= pipe_idx_q;
          res_id_q <= rel_q ? '0 : pipe_idx_q;
          res_st_q <= ST_FOUND;
        end else if (scan_miss) begin
          res_id_q <= '0;
          res_st_q <= rel_q ? ST_UNBOUND : ST_NOFREE;
        end
      end
      OP_GET_RD: begin
        lrd_addr_q <= free_head_q;
        cur_q      <= free_head_q;
      end
      OP_GET_LNK: begin
        res_id_q <= cur_q;
        res_st_q <= ST_NEW;
      end
      OP_REL_WR: begin
        res_id_q <= '0;
        res_st_q <= ST_REL;
      end
      OP_CLR_CHK: begin
        res_id_q <= '0;
        res_st_q <= ST_CLEARED;
      end
      OP_CLR_WR: begin
        nx_q <= next_rd;
      end
      OP_CLR_LNK: begin
        cur_q <= nx_q;
      end
      OP_DONE: begin
        if (out_free) begin
          out_id_q <= ID_OUT_W'(res_id_q);
          out_st_q <= res_st_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready  = (op_i == OP_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.id     = out_id_q;
  assign rsp_o.status = out_st_q;

  assign stat_o.in_valid   = req_i.valid;
  assign stat_o.in_clr     = req_i.cmd[1];
  assign stat_o.rel        = rel_q;
  assign stat_o.hit        = hit;
  assign stat_o.scan_miss  = scan_miss;
  assign stat_o.free_empty = (free_cnt_q == '0);
  assign stat_o.cur_zero   = (cur_q == '0);
  assign stat_o.out_free   = out_free;

endmodule

// File: hdl/key_to_id_allocator.sv
// Top level of the key to id allocator: controller plus datapath.
// Depends on kia_pkg, kia_if, kia_ctrl, kia_dp and the assertion header.
//
// Binds 64-bit keys to ids 1..ID_COUNT-1 (id 0 = none). One request word in,
// one response word out. Get and release search the key RAM one entry per
// cycle until a hit or a miss. A get that finds its key or no free id and a
// release of an unbound key then go to the done state; a get that binds a new
// id first passes the get read, write and link states, a release of a bound
// key the release read and write states. A clear walks the in-use list through
// the link RAMs, passing the clear check, read, write and link states per bound
// id. The done state holds while the output register is full and the response
// side holds off. One request is in flight at a time; the next is taken while
// the previous response sits in the output register. No clearing pass after reset.
`include "key_to_id_allocator_assert.svh"
module key_to_id_allocator (
  input  logic      clk_i,
  input  logic      rst_ni,
  kia_req_if.sink   req_i,
  kia_rsp_if.source rsp_o
);
  import kia_pkg::*;

  kia_op_e   op;
  kia_stat_t stat;

  kia_ctrl u_ctrl (
    .clk_i, .rst_ni, .stat_i(stat), .op_o(op)
  );

  kia_dp u_dp (
    .clk_i, .rst_ni, .op_i(op), .stat_o(stat), .req_i(req_i), .rsp_o(rsp_o)
  );

  // checks
  `KIA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready,
                   !req_i.ready, "second word taken while busy")
  `KIA_ASSERT_NOW(a_hit_miss_excl, clk_i, rst_ni, stat.hit, !stat.scan_miss,
                  "scan hit and miss together")
  `KIA_ASSERT_NOW(a_rsp_from_done, clk_i, rst_ni, $rose(rsp_o.valid),
                  $past(op == OP_DONE), "response without finished command")

endmodule

// File: tb/tb_key_to_id_allocator.sv
// Testbench of key_to_id_allocator: a directed table, then random get/release/clear
// words, checked against an in-bench model of the id lists. Needs kia_pkg, kia_if, RTL.
`timescale 1ns / 100ps
module tb_key_to_id_allocator;
  import kia_pkg::*;

  localparam logic [CMD_W-1:0] CMD_CLR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLR3 = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 1100;
  localparam int unsigned RANDOM_WORDS = 1800;

  typedef struct packed {
    logic [ID_OUT_W-1:0] id;
    kia_status_e         status;
  } id_rsp_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    bit               typed;
    id_rsp_t          rsp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  kia_req_if req ();
  kia_rsp_if rsp ();

  key_to_id_allocator dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // model state of the key bindings and both id lists
  logic [KEY_W-1:0] m_key   [ID_COUNT];
  bit               m_bound [ID_COUNT];
  int unsigned      m_flink [ID_COUNT];
  int unsigned      m_unext [ID_COUNT];
  int unsigned      m_uprev [ID_COUNT];
  int unsigned      m_fhead, m_ftail, m_fcount, m_uhead, m_utail;

  id_rsp_t     rsp_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned burst_left;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_key_to_id_allocator NOT OK");
      $finish;
    end
  end

  function automatic void model_reset();
    for (int i = 0; i < ID_COUNT; i++) begin
      m_bound[i] = 1'b0;
      m_key[i]   = '0;
      m_unext[i] = 0;
      m_uprev[i] = 0;
      m_flink[i] = (i + 1 < ID_COUNT) ? i + 1 : 0;
    end
    m_fhead = 1; m_ftail = ID_COUNT - 1; m_fcount = ID_COUNT - 1;
    m_uhead = 0; m_utail = 0;
  endfunction

  function automatic int unsigned lookup(logic [KEY_W-1:0] k);
    for (int i = 1; i < ID_COUNT; i++)
      if (m_bound[i] && m_key[i] == k) return i;
    return 0;
  endfunction

  // one word through the model: state update plus the response it yields
  function automatic id_rsp_t allocate_id(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k);
    id_rsp_t     r;
    int unsigned b, cur, nx, guard, p, n;
    r.id = '0;
    if (c[1]) begin
      // clear: walk the in-use list, append each id to the free tail
      cur = m_uhead; guard = 0;
      while (cur != 0 && cur < ID_COUNT && guard < ID_COUNT) begin
        nx = m_unext[cur];
        m_bound[cur] = 1'b0;
        m_flink[cur] = 0;
        if (m_fcount == 0) m_fhead = cur; else m_flink[m_ftail] = cur;
        m_ftail = cur; m_fcount++;
        cur = nx; guard++;
      end
      m_uhead = 0; m_utail = 0;
      r.status = ST_CLEARED;
    end else if (c == CMD_REL) begin
      b = lookup(k);
      if (b == 0) r.status = ST_UNBOUND;
      else begin
        m_bound[b] = 1'b0;
        p = m_uprev[b]; n = m_unext[b];
        if (p != 0) m_unext[p] = n; else m_uhead = n;
        if (n != 0) m_uprev[n] = p; else m_utail = p;
        if (m_fcount == 0) begin
          m_ftail = b; m_flink[b] = 0;
        end else m_flink[b] = m_fhead;
        m_fhead = b; m_fcount++;
        r.status = ST_REL;
      end
    end else begin
      b = lookup(k);
      if (b != 0) begin
        r.id = b[ID_OUT_W-1:0]; r.status = ST_FOUND;
      end else if (m_fcount == 0) r.status = ST_NOFREE;
      else begin
        b = m_fhead; m_fhead = m_flink[b]; m_fcount--;
        m_key[b] = k; m_bound[b] = 1'b1;
        m_uprev[b] = m_utail; m_unext[b] = 0;
        if (m_utail != 0) m_unext[m_utail] = b; else m_uhead = b;
        m_utail = b;
        r.id = b[ID_OUT_W-1:0]; r.status = ST_NEW;
      end
    end
    return r;
  endfunction

  // offer one word in bursts; on accept, queue its response
  task automatic send_word(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, bit typed,
                           id_rsp_t typed_rsp);
    int unsigned gap;
    id_rsp_t     r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req.valid <= 1'b1;
    req.cmd   <= c;
    req.key   <= k;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    r = allocate_id(c, k);
    rsp_q.push_back(typed ? typed_rsp : r);
    burst_left--;
  endtask

  // response side: check in order, stall in changing patterns
  initial begin
    int unsigned hold_left, mode, mode_left;
    id_rsp_t     e;
    hold_left = 0; mode = 0; mode_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp.valid && rsp.ready) begin
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected word id=%0d status=%0d", $time, rsp.id, rsp.status);
          errors++;
        end else begin
          e = rsp_q.pop_front();
          if (rsp.id !== e.id)
            $display("%0t: id mismatch expected %0d actual %0d", $time, e.id, rsp.id);
          if (rsp.status !== e.status)
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, e.status, rsp.status);
          if (rsp.id !== e.id || rsp.status !== e.status) errors++;
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else case (mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= 1'($urandom_range(0, 1));
        default: rsp.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // directed table; typed rows carry the response read straight off the spec
  dir_row_t dir_tab [16] = '{
    '{CMD_GET,  64'h0,                 1, '{8'd1, ST_NEW}},
    '{CMD_GET,  64'hFFFF_FFFF_FFFF_FFFF, 1, '{8'd2, ST_NEW}},
    '{CMD_GET,  64'h0,                 1, '{8'd1, ST_FOUND}},
    '{CMD_GET,  64'hFFFF_FFFF_FFFF_FFFF, 1, '{8'd2, ST_FOUND}},
    '{CMD_REL,  64'h0,                 1, '{8'd0, ST_REL}},
    '{CMD_REL,  64'h0,                 1, '{8'd0, ST_UNBOUND}},
    '{CMD_GET,  64'h5555_5555_5555_5555, 1, '{8'd1, ST_NEW}},
    '{CMD_GET,  64'hAAAA_AAAA_AAAA_AAAA, 0, '{8'd0, ST_FOUND}},
    '{CMD_REL,  64'h1234_5678_9ABC_DEF0, 1, '{8'd0, ST_UNBOUND}},
    '{CMD_GET,  64'h8000_0000_0000_0001, 0, '{8'd0, ST_FOUND}},
    '{CMD_REL,  64'hFFFF_FFFF_FFFF_FFFF, 0, '{8'd0, ST_FOUND}},
    '{CMD_CLR,  64'hFFFF_FFFF_FFFF_FFFF, 1, '{8'd0, ST_CLEARED}},
    '{CMD_CLR3, 64'h0,                 1, '{8'd0, ST_CLEARED}},
    '{CMD_GET,  64'h5555_5555_5555_5555, 0, '{8'd0, ST_FOUND}},
    '{CMD_GET,  64'h0,                 0, '{8'd0, ST_FOUND}},
    '{CMD_CLR3, 64'h7,                 1, '{8'd0, ST_CLEARED}}
  };

  // main sequence
  initial begin
    logic [KEY_W-1:0] pool [400];
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    int unsigned      sent, pool_n, phase, roll, drain;
    id_rsp_t          none;
    none = '{8'd0, ST_FOUND};
    errors = 0; burst_left = 0; hold_req = 1'b0;
    req.valid = 1'b0; req.cmd = CMD_GET; req.key = '0;
    rst_n = 1'b0;
    model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_word(dir_tab[i].cmd, dir_tab[i].key, dir_tab[i].typed, dir_tab[i].rsp);

    // random phases: fill to exhaustion, then churn over pools of varying size
    sent = 0; phase = 0;
    while (sent < RANDOM_WORDS) begin
      pool_n = (phase == 0) ? 400 : (($urandom_range(0, 1) == 0) ? 8 : 300);
      for (int i = 0; i < pool_n; i++) pool[i] = {$urandom, $urandom};
      if (phase == 2) hold_req = 1'b1;
      for (int j = 0; j < ((phase == 0) ? 320 : 150) && sent < RANDOM_WORDS; j++) begin
        roll = $urandom_range(0, 99);
        // distinct keys in the fill phase so every id gets bound
        k = (phase == 0) ? pool[j] : pool[$urandom_range(0, pool_n - 1)];
        if (phase != 0 && roll < 2) begin
          c = ($urandom_range(0, 1) == 0) ? CMD_CLR : CMD_CLR3;
          k = {$urandom, $urandom};
        end else if (phase != 0 && roll < 4) begin
          c = CMD_REL; k = {$urandom, $urandom};
        end else if (phase == 0 || roll < 65) c = CMD_GET;
        else c = CMD_REL;
        send_word(c, k, 0, none);
        sent++;
      end
      // after the second phase, let everything drain before the next phase
      if (phase == 1) begin
        req.valid <= 1'b0;
        burst_left = 0;
        while (rsp_q.size() != 0) @(posedge clk);
      end
      phase++;
    end
    req.valid <= 1'b0;

    while (rsp_q.size() != 0) @(posedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("tb_key_to_id_allocator OK");
    end else begin
      $display("tb_key_to_id_allocator NOT OK");
    end
    $finish;
  end

endmodule

// File: key_to_id_allocator.f
+incdir+hdl
hdl/kia_pkg.sv
hdl/kia_if.sv
hdl/kia_ram.sv
hdl/kia_ctrl.sv
hdl/kia_dp.sv
hdl/key_to_id_allocator.sv
tb/tb_key_to_id_allocator.sv
